@@ rtl/dtrc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Dirty tile run coalescer package
// Shared transaction types, command and status groups, and default constants.
// ----------------------------------------------------------------------------
package dtrc_pkg;

    localparam int TILES_PER_ROW_DEF = 128;
    localparam int TILE_ROWS_DEF     = 128;
    localparam int TILE_BYTES_DEF    = 128;

    localparam int WORD_W        = 32;
    localparam int POS_W         = 16;
    localparam int OFFSET_W      = 21;
    localparam int LENGTH_W      = 15;
    localparam int TB_W          = 13;
    localparam int RAM_DEPTH_DEF = 512;

    localparam logic KIND_MARK = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] position;
    } item_t;

    typedef struct packed {
        logic                ignored;
        logic                run_found;
        logic [OFFSET_W-1:0] run_offset;
        logic [LENGTH_W-1:0] run_length;
        logic                done_res;
    } result_t;

    typedef enum logic [1:0] {
        RES_MARK,
        RES_IGNORED,
        RES_FOUND,
        RES_DONE
    } res_kind_t;

    typedef struct packed {
        logic      clr;
        logic      load_item;
        logic      rd_item;
        logic      rd_ptr;
        logic      mark_wr;
        logic      scan_step;
        logic      rewind;
        logic      align_step;
        logic      run_step;
        logic      out_load;
        res_kind_t res_kind;
    } cmd_t;

    typedef struct packed {
        logic pos_out;
        logic ptr_end;
        logic scan_hit;
        logic scan_end;
        logic align_more;
        logic run_more;
        logic clr_last;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

@@ rtl/dtrc_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dtrc_ram #(
    parameter int WIDTH = dtrc_pkg::WORD_W,
    parameter int DEPTH = dtrc_pkg::RAM_DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/dtrc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Dirty tile run coalescer controller
// Sequences the clearing pass, marks, bitmap scans, row alignment and runs.
// ----------------------------------------------------------------------------
module dtrc_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    input  wire logic           item_kind,
    output logic                item_stall,
    input  wire dtrc_pkg::sts_t sts,
    output dtrc_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MARK,
        S_SCAN,
        S_ALIGN,
        S_RUN,
        S_RESP
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    dtrc_pkg::res_kind_t res_reg;
    dtrc_pkg::res_kind_t res_next;

    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        res_next     = res_reg;
        cmd          = '0;
        cmd.res_kind = res_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    case (item_kind)
                        dtrc_pkg::KIND_MARK:
                        begin
                            if (sts.pos_out)
                            begin
                                res_next   = dtrc_pkg::RES_IGNORED;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                cmd.rd_item = 1'b1;
                                state_next  = S_MARK;
                            end
                        end
                        dtrc_pkg::KIND_RUN:
                        begin
                            if (sts.ptr_end)
                            begin
                                cmd.rewind = 1'b1;
                                res_next   = dtrc_pkg::RES_DONE;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                cmd.rd_ptr = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MARK:
            begin
                cmd.mark_wr = 1'b1;
                res_next    = dtrc_pkg::RES_MARK;
                state_next  = S_RESP;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_hit)
                begin
                    state_next = S_ALIGN;
                end
                else if (sts.scan_end)
                begin
                    cmd.rewind = 1'b1;
                    res_next   = dtrc_pkg::RES_DONE;
                    state_next = S_RESP;
                end
            end
            S_ALIGN:
            begin
                cmd.align_step = 1'b1;
                if (!sts.align_more)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.run_step = 1'b1;
                if (!sts.run_more)
                begin
                    res_next   = dtrc_pkg::RES_FOUND;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            res_reg   <= dtrc_pkg::RES_MARK;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/dtrc_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Dirty tile run coalescer datapath
// Dirty bitmap RAM, scan pointer, row tracking, run extraction and result
// register.
// ----------------------------------------------------------------------------
module dtrc_dpath #(
    parameter int TILES_PER_ROW = dtrc_pkg::TILES_PER_ROW_DEF,
    parameter int TILE_ROWS     = dtrc_pkg::TILE_ROWS_DEF,
    parameter int TILE_BYTES    = dtrc_pkg::TILE_BYTES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dtrc_pkg::item_t   item,
    input  wire dtrc_pkg::cmd_t    cmd,
    output dtrc_pkg::sts_t         sts,
    input  wire logic              result_stall,
    output logic                   result_valid,
    output dtrc_pkg::result_t      result
);

    localparam int WW         = dtrc_pkg::WORD_W;
    localparam int TILE_TOTAL = TILES_PER_ROW * TILE_ROWS;
    localparam int WORDS      = (TILE_TOTAL + WW - 1) / WW;
    localparam int WADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PTR_W      = $clog2(WORDS * WW + 1);
    localparam int CNT_W      = $clog2(TILES_PER_ROW + 1);
    localparam int OFF_PROD_W = (PTR_W + dtrc_pkg::TB_W > dtrc_pkg::OFFSET_W)
                                ? PTR_W + dtrc_pkg::TB_W : dtrc_pkg::OFFSET_W;
    localparam int LEN_PROD_W = (CNT_W + dtrc_pkg::TB_W > dtrc_pkg::LENGTH_W)
                                ? CNT_W + dtrc_pkg::TB_W : dtrc_pkg::LENGTH_W;

    localparam logic [PTR_W-1:0]   TOTAL_C   = PTR_W'(TILE_TOTAL);
    localparam logic [PTR_W-1:0]   ROW_C     = PTR_W'(TILES_PER_ROW);
    localparam logic [PTR_W-1:0]   REV_INIT  = PTR_W'((TILE_ROWS - 1) * TILES_PER_ROW);
    localparam logic [PTR_W-1:0]   WORD_C    = PTR_W'(WW);
    localparam logic [dtrc_pkg::POS_W:0] POS_LIMIT = (dtrc_pkg::POS_W + 1)'(TILE_TOTAL);
    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORDS - 1);

    logic [dtrc_pkg::POS_W-1:0] pos_reg;
    logic [PTR_W-1:0]           ptr_reg;
    logic [PTR_W-1:0]           ptr_next;
    logic [PTR_W-1:0]           row_start_reg;
    logic [PTR_W-1:0]           row_start_next;
    logic [PTR_W-1:0]           rev_base_reg;
    logic [PTR_W-1:0]           rev_base_next;
    logic [PTR_W-1:0]           idx_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [WADDR_W-1:0]         clr_reg;
    logic                       result_valid_reg;
    logic                       result_valid_next;
    dtrc_pkg::result_t          result_reg;
    dtrc_pkg::result_t          result_next;

    logic [WW-1:0]         rd_data;
    logic                  wr_en;
    logic [WADDR_W-1:0]    wr_addr;
    logic [WW-1:0]         wr_data;
    logic                  rd_en;
    logic [WADDR_W-1:0]    rd_addr;

    logic [4:0]            ptr_bit;
    logic [PTR_W-1:0]      wbase;
    logic [PTR_W-1:0]      next_wbase;
    logic [PTR_W-1:0]      row_end;
    logic [WW-1:0]         masked;
    logic                  hit;
    logic [4:0]            hit_idx;
    logic                  scan_end;
    logic [PTR_W-1:0]      avail;
    logic [5:0]            lim;
    logic [WW-1:0]         lim_mask;
    logic [WW-1:0]         run_vec;
    logic [WW:0]           run_inv;
    logic [5:0]            run_n;
    logic [WW-1:0]         run_ones;
    logic [WW-1:0]         run_wr;
    logic [PTR_W-1:0]      ptr_new;
    logic [5:0]            run_end_bit;
    logic                  run_more;
    logic                  align_more;
    logic [OFF_PROD_W-1:0] off_prod;
    logic [LEN_PROD_W-1:0] len_prod;

    dtrc_ram #(
        .WIDTH (WW),
        .DEPTH (WORDS)
    ) u_bitmap (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign ptr_bit    = ptr_reg[4:0];
    assign wbase      = {ptr_reg[PTR_W-1:5], 5'b0};
    assign next_wbase = wbase + WORD_C;
    assign row_end    = row_start_reg + ROW_C;
    assign align_more = (ptr_reg >= row_end);

    // first dirty bit at or above the pointer within the current word
    assign masked = rd_data & ({WW{1'b1}} << ptr_bit);
    assign hit    = |masked;

    always_comb
    begin
        hit_idx = '0;
        for (int i = WW - 1; i >= 0; i--)
        begin
            if (masked[i])
            begin
                hit_idx = 5'(i);
            end
        end
    end

    assign scan_end = !hit && (next_wbase >= TOTAL_C);

    // run of set bits from the pointer, cut at the row end and the word end
    assign avail = row_end - wbase;
    assign lim   = (avail >= WORD_C) ? 6'(WW) : avail[5:0];

    always_comb
    begin
        for (int i = 0; i < WW; i++)
        begin
            lim_mask[i] = (6'(i) < lim);
        end
    end

    assign run_vec = (rd_data & lim_mask) >> ptr_bit;
    assign run_inv = {1'b1, ~run_vec};

    always_comb
    begin
        run_n = '0;
        for (int i = WW; i >= 0; i--)
        begin
            if (run_inv[i])
            begin
                run_n = 6'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < WW; i++)
        begin
            run_ones[i] = (6'(i) < run_n);
        end
    end

    assign run_wr      = rd_data & ~(run_ones << ptr_bit);
    assign ptr_new     = ptr_reg + PTR_W'(run_n);
    assign run_end_bit = {1'b0, ptr_bit} + run_n;
    assign run_more    = (run_end_bit == 6'(WW)) && (ptr_new < row_end);

    // bitmap ports
    always_comb
    begin
        wr_en = cmd.clr || cmd.mark_wr || cmd.run_step;
        if (cmd.clr)
        begin
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else if (cmd.mark_wr)
        begin
            wr_addr = pos_reg[WADDR_W+4:5];
            wr_data = rd_data | (WW'(1) << pos_reg[4:0]);
        end
        else
        begin
            wr_addr = ptr_reg[WADDR_W+4:5];
            wr_data = run_wr;
        end
    end

    always_comb
    begin
        rd_en = cmd.rd_item || cmd.rd_ptr
                || (cmd.scan_step && !hit && !scan_end)
                || (cmd.run_step && run_more);
        if (cmd.rd_item)
        begin
            rd_addr = item.position[WADDR_W+4:5];
        end
        else if (cmd.rd_ptr)
        begin
            rd_addr = ptr_reg[WADDR_W+4:5];
        end
        else if (cmd.scan_step)
        begin
            rd_addr = next_wbase[WADDR_W+4:5];
        end
        else
        begin
            rd_addr = ptr_new[WADDR_W+4:5];
        end
    end

    assign sts.pos_out    = ({1'b0, item.position} >= POS_LIMIT);
    assign sts.ptr_end    = (ptr_reg >= TOTAL_C);
    assign sts.scan_hit   = hit;
    assign sts.scan_end   = scan_end;
    assign sts.align_more = align_more;
    assign sts.run_more   = run_more;
    assign sts.clr_last   = (clr_reg == LAST_WORD);
    assign sts.out_free   = !result_valid_reg || !result_stall;

    always_comb
    begin
        ptr_next       = ptr_reg;
        row_start_next = row_start_reg;
        rev_base_next  = rev_base_reg;
        if (cmd.rewind)
        begin
            ptr_next       = '0;
            row_start_next = '0;
            rev_base_next  = REV_INIT;
        end
        else if (cmd.scan_step)
        begin
            ptr_next = hit ? {ptr_reg[PTR_W-1:5], hit_idx} : next_wbase;
        end
        else if (cmd.align_step && align_more)
        begin
            row_start_next = row_start_reg + ROW_C;
            rev_base_next  = rev_base_reg - ROW_C;
        end
        else if (cmd.run_step)
        begin
            ptr_next = ptr_new;
        end
    end

    assign off_prod = OFF_PROD_W'(idx_reg) * OFF_PROD_W'(TILE_BYTES);
    assign len_prod = LEN_PROD_W'(cnt_reg) * LEN_PROD_W'(TILE_BYTES);

    always_comb
    begin
        result_next            = '0;
        result_next.ignored    = (cmd.res_kind == dtrc_pkg::RES_IGNORED);
        result_next.done_res   = (cmd.res_kind == dtrc_pkg::RES_DONE);
        result_next.run_found  = (cmd.res_kind == dtrc_pkg::RES_FOUND);
        if (cmd.res_kind == dtrc_pkg::RES_FOUND)
        begin
            result_next.run_offset = off_prod[dtrc_pkg::OFFSET_W-1:0];
            result_next.run_length = len_prod[dtrc_pkg::LENGTH_W-1:0];
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg          <= '0;
            row_start_reg    <= '0;
            rev_base_reg     <= REV_INIT;
            clr_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg          <= ptr_next;
            row_start_reg    <= row_start_next;
            rev_base_reg     <= rev_base_next;
            result_valid_reg <= result_valid_next;
            if (cmd.clr)
            begin
                clr_reg <= clr_reg + WADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            pos_reg <= item.position;
        end
        if (cmd.align_step && !align_more)
        begin
            idx_reg <= rev_base_reg + ptr_reg - row_start_reg;
            cnt_reg <= '0;
        end
        if (cmd.run_step)
        begin
            cnt_reg <= cnt_reg + CNT_W'(run_n);
        end
        if (cmd.out_load)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

@@ rtl/dirty_tile_run_coalescer_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Dirty tile run coalescer
// Dirty bitmap over a bottom-up tile store, returning contiguous copy runs.
// ----------------------------------------------------------------------------
// A mark transaction sets the dirty bit of one tile (or reports it ignored
// when it lies beyond the grid); a run transaction returns the byte offset and
// length of the next run of dirty tiles at or after the scan pointer, clears
// them, and reports done and rewinds once none remain. After reset the bitmap
// is cleared one word per cycle, ceil(TILES_PER_ROW*TILE_ROWS/32) words (512
// by default), with item_stall held high. A mark reads its bitmap word and
// writes it back with the bit set; a mark beyond the grid skips both. A run
// scans the bitmap word by word, takes one alignment step per row boundary
// passed since the previous run plus one, and reads each bitmap word of the
// run, one more than it covers when it stops on a word boundary short of the
// row end. A run that finds nothing reports done after the last word, or
// without a read when the pointer is already past the last tile. The bitmap
// RAM has a single read port, so these reads follow one another. One
// transaction is in work at a time; a finished result waits in the output
// register while the next transaction is taken, and a result that finds that
// register still stalled waits until it frees.
module dirty_tile_run_coalescer_core #(
    parameter int TILES_PER_ROW = dtrc_pkg::TILES_PER_ROW_DEF,
    parameter int TILE_ROWS     = dtrc_pkg::TILE_ROWS_DEF,
    parameter int TILE_BYTES    = dtrc_pkg::TILE_BYTES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire dtrc_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output dtrc_pkg::result_t      result
);

    dtrc_pkg::cmd_t cmd;
    dtrc_pkg::sts_t sts;

    dtrc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_kind  (item.kind),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    dtrc_dpath #(
        .TILES_PER_ROW (TILES_PER_ROW),
        .TILE_ROWS     (TILE_ROWS),
        .TILE_BYTES    (TILE_BYTES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

    // one transaction in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("transaction accepted while another in work");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(result_valid && result_stall))
        else $error("waiting result overwritten");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $onehot0({result.ignored, result.run_found, result.done_res}))
        else $error("conflicting result flags");

    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.run_found)
            |-> (result.run_offset == '0 && result.run_length == '0))
        else $error("run fields set without a run");

endmodule
`default_nettype wire
